// ===== hw/rtl/bbcg_pkg.sv =====
// Byte classes, actions, framing states and check functions of the BSC block check generator.
`timescale 1ns / 1ps

package bbcg_pkg;

	// Reflected CRC-16 polynomial, LRC flip mask and the DLE code.
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [7:0]  LRC_FLIP = 8'h80;
	localparam logic [7:0]  DLE_CODE = 8'h10;

	// Control codes that both tables share.
	localparam logic [7:0] SOB_CODE_A = 8'h01;
	localparam logic [7:0] SOB_CODE_B = 8'h02;
	localparam logic [7:0] ITB_CODE   = 8'h1F;
	localparam logic [7:0] EOB_CODE   = 8'h03;

	// Codes of the ASCII table.
	localparam logic [7:0] ASC_EOB_A = 8'h17;
	localparam logic [7:0] ASC_EOB_B = 8'h83;
	localparam logic [7:0] ASC_EOB_C = 8'h97;
	localparam logic [7:0] ASC_SYN   = 8'h16;

	// Codes of the EBCDIC table.
	localparam logic [7:0] EBC_EOB = 8'h26;
	localparam logic [7:0] EBC_SYN = 8'h32;

	// Byte classes.
	typedef enum logic [2:0] {
		CLS_SYN = 3'd0,
		CLS_SOB = 3'd1,
		CLS_DLE = 3'd2,
		CLS_GPH = 3'd3,
		CLS_EOB = 3'd4,
		CLS_ITB = 3'd5
	} byte_class_t;

	// Actions taken for one byte.
	typedef enum logic [2:0] {
		ACT_SKIP   = 3'd0,
		ACT_ADD    = 3'd1,
		ACT_CLOSE  = 3'd2,
		ACT_DLESOB = 3'd3,
		ACT_ERR    = 3'd4
	} action_t;

	// Framing machine states.
	typedef enum logic [2:0] {
		FS_ST0 = 3'd0,
		FS_ST1 = 3'd1,
		FS_ST2 = 3'd2,
		FS_ST3 = 3'd3,
		FS_ST4 = 3'd4
	} frame_state_t;

	// Classify a byte against the ASCII or the EBCDIC table.
	function automatic byte_class_t classify(input logic [7:0] b, input logic ascii);
		byte_class_t cls;
		cls = CLS_GPH;
		if (b == SOB_CODE_A || b == SOB_CODE_B) begin
			cls = CLS_SOB;
		end else if (b == DLE_CODE) begin
			cls = CLS_DLE;
		end else if (b == ITB_CODE) begin
			cls = CLS_ITB;
		end else if (b == EOB_CODE) begin
			cls = CLS_EOB;
		end else if (ascii) begin
			if (b == ASC_EOB_A || b == ASC_EOB_B || b == ASC_EOB_C) begin
				cls = CLS_EOB;
			end else if (b == ASC_SYN) begin
				cls = CLS_SYN;
			end
		end else begin
			if (b == EBC_EOB) begin
				cls = CLS_EOB;
			end else if (b == EBC_SYN) begin
				cls = CLS_SYN;
			end
		end
		return cls;
	endfunction

	// One CRC byte: eight reflected shift steps, then the byte into bits 15:8.
	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c;
		for (int i = 0; i < 8; i++) begin
			r = (r >> 1) ^ (r[0] ? CRC_POLY : 16'h0000);
		end
		return r ^ {b, 8'h00};
	endfunction

	// Accumulate one byte in CRC or LRC mode.
	function automatic logic [15:0] accumulate(input logic [15:0] c, input logic [7:0] b,
			input logic crc);
		logic [15:0] r;
		if (crc) begin
			r = crc_byte(c, b);
		end else begin
			r = c ^ {8'h00, b ^ LRC_FLIP};
		end
		return r;
	endfunction

	// Next framing state by byte class and current state.
	function automatic frame_state_t next_state(input byte_class_t cls, input frame_state_t st);
		frame_state_t ns;
		ns = FS_ST4;
		case (cls)
			CLS_SYN: begin
				case (st)
					FS_ST1, FS_ST2: ns = FS_ST1;
					FS_ST3: ns = FS_ST4;
					FS_ST4: ns = FS_ST4;
					default: ns = FS_ST0;
				endcase
			end
			CLS_SOB: begin
				case (st)
					FS_ST0, FS_ST1: ns = FS_ST1;
					default: ns = FS_ST4;
				endcase
			end
			CLS_DLE: begin
				case (st)
					FS_ST2: ns = FS_ST1;
					FS_ST3: ns = FS_ST4;
					FS_ST4: ns = FS_ST3;
					default: ns = FS_ST2;
				endcase
			end
			CLS_GPH: begin
				case (st)
					FS_ST3: ns = FS_ST4;
					FS_ST4: ns = FS_ST4;
					default: ns = FS_ST1;
				endcase
			end
			CLS_EOB: begin
				case (st)
					FS_ST2: ns = FS_ST1;
					FS_ST4: ns = FS_ST4;
					default: ns = FS_ST0;
				endcase
			end
			CLS_ITB: begin
				case (st)
					FS_ST4: ns = FS_ST4;
					default: ns = FS_ST1;
				endcase
			end
			default: ns = FS_ST4;
		endcase
		return ns;
	endfunction

	// Action by byte class and current state.
	function automatic action_t action_of(input byte_class_t cls, input frame_state_t st);
		action_t act;
		act = ACT_SKIP;
		case (cls)
			CLS_SYN: begin
				case (st)
					FS_ST2: act = ACT_ERR;
					FS_ST4: act = ACT_ADD;
					default: act = ACT_SKIP;
				endcase
			end
			CLS_SOB: begin
				case (st)
					FS_ST1: act = ACT_ADD;
					FS_ST2: act = ACT_DLESOB;
					FS_ST3: act = ACT_ERR;
					FS_ST4: act = ACT_ADD;
					default: act = ACT_SKIP;
				endcase
			end
			CLS_DLE: begin
				case (st)
					FS_ST2: act = ACT_ERR;
					FS_ST3: act = ACT_ADD;
					default: act = ACT_SKIP;
				endcase
			end
			CLS_GPH: begin
				case (st)
					FS_ST2: act = ACT_ERR;
					default: act = ACT_ADD;
				endcase
			end
			CLS_EOB, CLS_ITB: begin
				case (st)
					FS_ST2: act = ACT_ERR;
					FS_ST4: act = ACT_ADD;
					default: act = ACT_CLOSE;
				endcase
			end
			default: act = ACT_SKIP;
		endcase
		return act;
	endfunction

endpackage

// ===== hw/rtl/bisync_block_check_generator_core.sv =====
// BSC block check generator: one frame byte in, the running CRC-16 or LRC out.
`timescale 1ns / 1ps

// Takes one BSC frame byte per transaction and returns one result transaction per byte with
// the running block check, a block-close flag, a sequence-error flag and an echo of
// last_byte. Throughput is one byte per clock cycle while result_stall does not hold the
// result register. An accepted byte reaches its result through the input register, then
// the result register. A byte marked first_byte restarts the frame and selects the ASCII
// table with LRC (lrc_mode high) or the EBCDIC table with CRC-16. The cycle time is set by
// the framing lookup followed by up to 24 unrolled CRC shift steps between those registers.
module bisync_block_check_generator_core (
	input  logic        clk,
	input  logic        arst_n,
	// Byte channel.
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        lrc_mode,
	input  logic        last_byte,
	// Result channel.
	output logic        result_valid,
	input  logic        result_stall,
	output logic [15:0] check_value,
	output logic        block_closed,
	output logic        sequence_error,
	output logic        frame_done
);

	// Input stage registers.
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        first_s1;
	logic        lrc_s1;
	logic        last_s1;

	// Result stage registers.
	logic        valid_s2;
	logic [15:0] check_s2;
	logic        closed_s2;
	logic        err_s2;
	logic        last_s2;

	// Frame state registers.
	bbcg_pkg::frame_state_t fs_q;
	logic [15:0]            acc_q;
	logic [1:0]             seen_q;
	logic                   crc_q;
	logic                   ascii_q;

	// Effective state after a frame restart, and the computed next state.
	bbcg_pkg::frame_state_t fs_cur;
	logic [15:0]            acc_cur;
	logic [1:0]             seen_cur;
	logic                   crc_cur;
	logic                   ascii_cur;
	bbcg_pkg::byte_class_t  cls;
	bbcg_pkg::action_t      act;
	bbcg_pkg::frame_state_t fs_d;
	logic [15:0]            acc_d;
	logic [1:0]             seen_d;
	logic                   crc_d;
	logic                   closed_d;
	logic                   err_d;

	logic adv_s2;
	logic adv_s1;

	// Handshake: the result register frees when empty or taken, the input stage follows.
	assign adv_s2     = !valid_s2 || !result_stall;
	assign adv_s1     = valid_s1 && adv_s2;
	assign byte_stall = valid_s1 && !adv_s2;

	// A first byte clears the frame state and latches the mode before the byte is handled.
	always_comb begin
		if (first_s1) begin
			fs_cur    = bbcg_pkg::FS_ST0;
			acc_cur   = 16'h0000;
			seen_cur  = 2'd0;
			crc_cur   = !lrc_s1;
			ascii_cur = lrc_s1;
		end else begin
			fs_cur    = fs_q;
			acc_cur   = acc_q;
			seen_cur  = seen_q;
			crc_cur   = crc_q;
			ascii_cur = ascii_q;
		end
	end

	// Classification and next framing state.
	always_comb begin
		cls  = bbcg_pkg::classify(data_s1, ascii_cur);
		fs_d = bbcg_pkg::next_state(cls, fs_cur);
	end

	// Action: accumulator, mode, flags and byte count.
	always_comb begin
		act      = bbcg_pkg::action_of(cls, fs_cur);
		acc_d    = acc_cur;
		crc_d    = crc_cur;
		closed_d = 1'b0;
		err_d    = 1'b0;
		case (act)
			bbcg_pkg::ACT_ADD: begin
				acc_d = bbcg_pkg::accumulate(acc_cur, data_s1, crc_cur);
			end
			bbcg_pkg::ACT_CLOSE: begin
				acc_d = bbcg_pkg::accumulate(acc_cur, data_s1, crc_cur);
				if (crc_cur) begin
					acc_d = bbcg_pkg::crc_byte(bbcg_pkg::crc_byte(acc_d, 8'h00), 8'h00);
				end
				closed_d = 1'b1;
			end
			bbcg_pkg::ACT_DLESOB: begin
				crc_d = 1'b1;
				if (seen_cur == 2'd2) begin
					acc_d = bbcg_pkg::crc_byte(bbcg_pkg::crc_byte(acc_cur, bbcg_pkg::DLE_CODE),
						data_s1);
				end
			end
			bbcg_pkg::ACT_ERR: begin
				err_d = 1'b1;
			end
			default: begin
				acc_d = acc_cur;
			end
		endcase
		seen_d = (seen_cur == 2'd2) ? seen_cur : seen_cur + 2'd1;
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!byte_stall) begin
				valid_s1 <= byte_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			data_s1  <= data_byte;
			first_s1 <= first_byte;
			lrc_s1   <= lrc_mode;
			last_s1  <= last_byte;
		end
	end

	// Result stage payload.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			check_s2  <= acc_d;
			closed_s2 <= closed_d;
			err_s2    <= err_d;
			last_s2   <= last_s1;
		end
	end

	// Frame state, updated once per handled byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q    <= bbcg_pkg::FS_ST0;
			acc_q   <= 16'h0000;
			seen_q  <= 2'd0;
			crc_q   <= 1'b1;
			ascii_q <= 1'b0;
		end else if (adv_s1) begin
			fs_q    <= fs_d;
			acc_q   <= acc_d;
			seen_q  <= seen_d;
			crc_q   <= crc_d;
			ascii_q <= ascii_cur;
		end
	end

	// Result outputs.
	assign result_valid   = valid_s2;
	assign check_value    = check_s2;
	assign block_closed   = closed_s2;
	assign sequence_error = err_s2;
	assign frame_done     = last_s2;

endmodule
